@@ hw/rtl/ppse_pkg.sv @@
`default_nettype none

package ppse_pkg;

    localparam int LINE_BYTES = 80;
    localparam int LINES      = 480;

    localparam int DEPTH      = LINE_BYTES * LINES;
    localparam int ROW_PIXELS = LINE_BYTES * 8;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int WORD_W  = 32;
    localparam int PLANES  = 4;
    localparam int REQ_W   = 2;
    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int C_W     = 4;

    localparam int COL_W   = $clog2(ROW_PIXELS + 1);
    localparam int EXT_W   = (COL_W > X_W) ? COL_W : X_W;
    localparam int ROWS_W  = $clog2(LINES + 1);
    localparam int YEXT_W  = (ROWS_W > Y_W) ? ROWS_W : Y_W;
    localparam int SPAN_W  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int PRODR_W = Y_W + $clog2(LINE_BYTES + 1) + 1;
    localparam int PROD_W  = (PRODR_W > ADDR_W) ? PRODR_W : ADDR_W;

    localparam logic [7:0] FULL_MASK = 8'hFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT,
        REQ_GET,
        REQ_LINE
    } t_req_code;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_READ,
        ACT_ZERO
    } t_act;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_GET
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [X_W-1:0]   x;
        logic [X_W-1:0]   x_end;
        logic [Y_W-1:0]   y;
        logic [C_W-1:0]   colour;
    } t_req;

    typedef struct packed {
        logic [C_W-1:0] pixel_colour;
    } t_rsp;

    typedef struct packed {
        t_act              act;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        lmask;
        logic [7:0]        rmask;
        logic [SPAN_W-1:0] span;
        logic [2:0]        bit_sel;
    } t_dec;

endpackage

`default_nettype wire

@@ hw/rtl/ppse_req_if.sv @@
`default_nettype none

interface ppse_req_if;
    logic          valid;
    logic          ready;
    ppse_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ppse_rsp_if.sv @@
`default_nettype none

interface ppse_rsp_if;
    logic          valid;
    logic          ready;
    ppse_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/planar_pixel_span_engine_unit.sv @@
// Put pixel: one read and one write of the plane word per transaction.
// Get pixel: the RAM reads the plane word, then its colour is registered once the result slot is free.
// Horizontal line: each byte of the span is merged with the colour over the single RAM port pair.
// Reset clears the state, address, span and valid registers, then sweeps all LINE_BYTES * LINES words
// (38400) of the frame store to zero, one word a cycle; requests are held off until the sweep is done.
`default_nettype none

module planar_pixel_span_engine_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ppse_req_if.sink  i_req,
    ppse_rsp_if.source o_rsp
);
    import ppse_pkg::*;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [SPAN_W-1:0]  r_left, n_left;
    logic               r_first, n_first;
    logic [7:0]         r_lmask, n_lmask;
    logic [7:0]         r_rmask, n_rmask;
    logic [C_W-1:0]     r_colour, n_colour;
    logic [2:0]         r_bit, n_bit;
    logic               r_zero, n_zero;
    logic               r_out_valid, n_out_valid;
    logic [C_W-1:0]     r_out_colour, n_out_colour;

    t_dec               dec;
    logic               in_acc;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;
    logic [7:0]         mask;
    logic [WORD_W-1:0]  merged;
    logic [C_W-1:0]     gathered;

    ppse_req_decode u_decode (
        .i_req (i_req.payload),
        .o_dec (dec)
    );

    ppse_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready       = (r_state == ST_IDLE);
    assign in_acc            = i_req.valid && i_req.ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.payload.pixel_colour = r_out_colour;

    always_comb begin
        mask = (r_first ? r_lmask : FULL_MASK) & ((r_left == '0) ? r_rmask : FULL_MASK);
        for (int p = 0; p < PLANES; p++) begin
            for (int k = 0; k < 8; k++) begin
                merged[8*p+k] = mask[k] ? r_colour[p] : ram_rdata[8*p+k];
            end
            gathered[p] = ram_rdata[8*p + int'(r_bit)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_left      <= '0;
            r_first     <= 1'b0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_left      <= n_left;
            r_first     <= n_first;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
        r_lmask      <= n_lmask;
        r_rmask      <= n_rmask;
        r_colour     <= n_colour;
        r_bit        <= n_bit;
        r_out_colour <= n_out_colour;
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_left       = r_left;
        n_first      = r_first;
        n_zero       = r_zero;
        n_lmask      = r_lmask;
        n_rmask      = r_rmask;
        n_colour     = r_colour;
        n_bit        = r_bit;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_colour = r_out_colour;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = merged;
        ram_re       = 1'b0;
        ram_raddr    = dec.addr;

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_addr    = r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_addr   = dec.addr;
                    n_left   = dec.span;
                    n_first  = 1'b1;
                    n_lmask  = dec.lmask;
                    n_rmask  = dec.rmask;
                    n_colour = i_req.payload.colour;
                    n_bit    = dec.bit_sel;
                    n_zero   = 1'b0;
                    case (dec.act)
                        ACT_WRITE: begin
                            ram_re  = 1'b1;
                            n_state = ST_WRITE;
                        end
                        ACT_READ: begin
                            ram_re  = 1'b1;
                            n_state = ST_GET;
                        end
                        ACT_ZERO: begin
                            n_zero  = 1'b1;
                            n_state = ST_GET;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                ram_we = 1'b1;
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr + ADDR_W'(1);
                    n_addr    = r_addr + ADDR_W'(1);
                    n_left    = r_left - SPAN_W'(1);
                    n_first   = 1'b0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_GET: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_colour = r_zero ? '0 : gathered;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

`default_nettype wire

@@ hw/rtl/ppse_ram.sv @@
`default_nettype none

module ppse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

@@ hw/rtl/ppse_req_decode.sv @@
`default_nettype none

module ppse_req_decode (
    input  wire ppse_pkg::t_req i_req,
    output ppse_pkg::t_dec      o_dec
);
    import ppse_pkg::*;

    logic [EXT_W-1:0]  x_e;
    logic [EXT_W-1:0]  xe_e;
    logic [YEXT_W-1:0] y_e;
    logic [EXT_W-1:0]  end_c;
    logic [EXT_W-1:0]  end_m1;
    logic [EXT_W-1:0]  span_e;
    logic [PROD_W-1:0] prod;
    logic              row_ok;
    logic              col_ok;

    always_comb begin
        x_e    = EXT_W'(i_req.x);
        xe_e   = EXT_W'(i_req.x_end);
        y_e    = YEXT_W'(i_req.y);
        row_ok = y_e < YEXT_W'(LINES);
        col_ok = x_e < EXT_W'(ROW_PIXELS);
        end_c  = (xe_e > EXT_W'(ROW_PIXELS)) ? EXT_W'(ROW_PIXELS) : xe_e;
        end_m1 = end_c - EXT_W'(1);
        span_e = (end_m1 >> 3) - (x_e >> 3);
        prod   = PROD_W'(i_req.y) * PROD_W'(LINE_BYTES) + PROD_W'(i_req.x[X_W-1:3]);

        o_dec.act     = ACT_NONE;
        o_dec.addr    = prod[ADDR_W-1:0];
        o_dec.lmask   = FULL_MASK >> i_req.x[2:0];
        o_dec.rmask   = FULL_MASK << (3'd7 - i_req.x[2:0]);
        o_dec.span    = '0;
        o_dec.bit_sel = 3'd7 - i_req.x[2:0];

        case (i_req.req_type)
            REQ_PUT: begin
                if (row_ok && col_ok) begin
                    o_dec.act = ACT_WRITE;
                end
            end
            REQ_GET: begin
                o_dec.act = (row_ok && col_ok) ? ACT_READ : ACT_ZERO;
            end
            REQ_LINE: begin
                o_dec.rmask = FULL_MASK << (3'd7 - end_m1[2:0]);
                o_dec.span  = span_e[SPAN_W-1:0];
                if (row_ok && (x_e < end_c)) begin
                    o_dec.act = ACT_WRITE;
                end
            end
            default: begin
                o_dec.act = ACT_NONE;
            end
        endcase
    end
endmodule

`default_nettype wire

@@ hw/rtl/ppse_chk.sv @@
`default_nettype none

module ppse_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           i_in_ready,
    input wire logic [1:0]     i_in_req_type,
    input wire logic           i_out_valid,
    input wire logic           i_out_ready,
    input wire logic [3:0]     i_out_colour
);
    import ppse_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_reset_no_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid right after reset.");

    a_clear_blocks_requests: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_in_ready)
        else $error("Request accepted before the frame store sweep.");

    a_get_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_req_type == REQ_GET) && !i_out_valid) |-> ##2 i_out_valid)
        else $error("Get pixel transaction gave no result in time.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_colour)))
        else $error("Stalled result changed.");
endmodule

bind planar_pixel_span_engine_unit ppse_chk u_ppse_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_in_req_type (i_req.payload.req_type),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_out_colour  (o_rsp.payload.pixel_colour)
);

`default_nettype wire

@@ bench/planar_pixel_span_engine_unit_chk.sv @@
`timescale 1ns / 100ps

module planar_pixel_span_engine_unit_chk (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ppse_req_if       i_req,
    ppse_rsp_if       i_rsp,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);
    import ppse_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [C_W-1:0] colour;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } t_readback;

    logic [WORD_W-1:0] plane_words [DEPTH];
    t_readback         readbacks_due [$];
    int                fails   = 0;
    int                checked = 0;

    task automatic note_fail(string what);
        fails++;
        if (fails <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    task automatic paint(int unsigned addr, logic [7:0] mask, logic [C_W-1:0] colour);
        if (addr >= DEPTH) return;
        for (int p = 0; p < PLANES; p++) begin
            if (colour[p]) begin
                plane_words[addr][8*p +: 8] = plane_words[addr][8*p +: 8] | mask;
            end else begin
                plane_words[addr][8*p +: 8] = plane_words[addr][8*p +: 8] & ~mask;
            end
        end
    endtask

    function automatic logic [C_W-1:0] read_colour(t_req r);
        int unsigned       addr;
        logic [WORD_W-1:0] w;
        int unsigned       bit_idx;
        logic [C_W-1:0]    c;
        c = '0;
        if (r.y < LINES && r.x < ROW_PIXELS) begin
            addr    = r.y * LINE_BYTES + r.x / 8;
            w       = plane_words[addr];
            bit_idx = 7 - r.x[2:0];
            for (int p = 0; p < PLANES; p++) c[p] = w[8*p + bit_idx];
        end
        return c;
    endfunction

    task automatic draw_span(t_req r);
        int unsigned stop;
        int unsigned base;
        int unsigned lo;
        int unsigned hi;
        logic [7:0]  mask;
        if (r.y >= LINES) return;
        stop = (r.x_end > ROW_PIXELS) ? ROW_PIXELS : r.x_end;
        if (r.x >= stop) return;
        for (int unsigned b = r.x / 8; b <= (stop - 1) / 8; b++) begin
            base = b * 8;
            lo   = (r.x > base) ? r.x : base;
            hi   = (stop < base + 8) ? stop : base + 8;
            mask = (FULL_MASK >> (lo - base)) & (FULL_MASK << (8 - (hi - base)));
            paint(r.y * LINE_BYTES + b, mask, r.colour);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_req      req;
        t_readback want;
        if (!i_rst_n) begin
            foreach (plane_words[a]) plane_words[a] = '0;
            readbacks_due.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (readbacks_due.size() == 0) begin
                    note_fail($sformatf("unexpected response, pixel_colour %0d",
                                        i_rsp.payload.pixel_colour));
                end else begin
                    want = readbacks_due.pop_front();
                    checked++;
                    if (i_rsp.payload.pixel_colour !== want.colour) begin
                        note_fail($sformatf("pixel (%0d,%0d) colour expected %0d, got %0d",
                                            want.x, want.y, want.colour,
                                            i_rsp.payload.pixel_colour));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                req = i_req.payload;
                case (req.req_type)
                    REQ_PUT: begin
                        if (req.y < LINES && req.x < ROW_PIXELS) begin
                            paint(req.y * LINE_BYTES + req.x / 8, 8'h80 >> req.x[2:0],
                                  req.colour);
                        end
                    end
                    REQ_GET: begin
                        want.colour = read_colour(req);
                        want.x      = req.x;
                        want.y      = req.y;
                        readbacks_due.push_back(want);
                    end
                    REQ_LINE: draw_span(req);
                    default: ;
                endcase
            end
        end
        o_pending    <= readbacks_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end
endmodule

@@ bench/planar_pixel_span_engine_unit_tb.sv @@
`timescale 1ns / 100ps

module planar_pixel_span_engine_unit_tb;
    import ppse_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int IDLE_PCT      = 13;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 500;
    localparam int HOLD_GETS     = 40;
    localparam int QUIET_FROM    = 800;
    localparam int QUIET_TO      = 1000;
    localparam int PAUSE_AT      = 1100;
    localparam int DRAIN_CYCLES  = 200;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppse_req_if req_if ();
    ppse_rsp_if rsp_if ();

    int   fail_count;
    int   pending;
    int   checked;
    logic quiet      = 1'b0;
    logic hold_ask   = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;
    int   n_put      = 0;
    int   n_get      = 0;
    int   n_line     = 0;
    int   n_spare    = 0;

    planar_pixel_span_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    planar_pixel_span_engine_unit_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("planar_pixel_span_engine_unit_tb: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_ask && !hold_taken) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_taken   <= 1'b1;
        end else begin
            rsp_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic t_req mk(logic [REQ_W-1:0] code, int unsigned x, int unsigned x_end,
                                int unsigned y, int unsigned colour);
        t_req r;
        r.req_type = code;
        r.x        = X_W'(x);
        r.x_end    = X_W'(x_end);
        r.y        = Y_W'(y);
        r.colour   = C_W'(colour);
        return r;
    endfunction

    task automatic send(t_req item);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        do @(posedge i_clk); while (!req_if.ready);
        case (item.req_type)
            REQ_PUT:  n_put++;
            REQ_GET:  n_get++;
            REQ_LINE: n_line++;
            default:  n_spare++;
        endcase
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_req plan [$];
        t_req item;
        int   sel;
        int   win_x;
        int   win_y;

        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        i_rst_n        <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(mk(REQ_PUT, 0, 0, 0, 15));
        plan.push_back(mk(REQ_GET, 0, 0, 0, 0));
        plan.push_back(mk(REQ_PUT, 639, 1023, 479, 10));
        plan.push_back(mk(REQ_GET, 639, 0, 479, 15));
        plan.push_back(mk(REQ_PUT, 1023, 1023, 511, 15));
        plan.push_back(mk(REQ_GET, 1023, 1023, 511, 15));
        plan.push_back(mk(REQ_PUT, 640, 0, 0, 5));
        plan.push_back(mk(REQ_GET, 640, 0, 0, 0));
        plan.push_back(mk(REQ_PUT, 5, 0, 480, 15));
        plan.push_back(mk(REQ_GET, 5, 0, 480, 0));
        plan.push_back(mk(REQ_LINE, 0, 640, 1, 9));
        plan.push_back(mk(REQ_GET, 639, 0, 1, 0));
        plan.push_back(mk(REQ_LINE, 3, 1023, 2, 6));
        plan.push_back(mk(REQ_GET, 2, 0, 2, 0));
        plan.push_back(mk(REQ_GET, 3, 0, 2, 0));
        plan.push_back(mk(REQ_LINE, 10, 10, 3, 15));
        plan.push_back(mk(REQ_LINE, 700, 1023, 3, 15));
        plan.push_back(mk(REQ_GET, 10, 0, 3, 0));
        plan.push_back(mk(REQ_LINE, 9, 14, 4, 12));
        plan.push_back(mk(REQ_GET, 13, 0, 4, 0));
        plan.push_back(mk(REQ_GET, 14, 0, 4, 0));
        plan.push_back(mk(REQ_LINE, 0, 640, 480, 15));
        plan.push_back(mk(REQ_SPARE, 1023, 1023, 511, 15));
        plan.push_back(mk(REQ_PUT, 0, 0, 0, 0));
        plan.push_back(mk(REQ_GET, 0, 0, 0, 0));
        plan.push_back(mk(REQ_LINE, 1, 639, 479, 3));
        plan.push_back(mk(REQ_GET, 638, 0, 479, 0));
        foreach (plan[k]) send(plan[k]);

        win_x = 0;
        win_y = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet <= (i >= QUIET_FROM && i < QUIET_TO);
            if (i == HOLD_AT) hold_ask <= 1'b1;
            if (i == PAUSE_AT) wait_drained();
            if (i % 50 == 0) begin
                win_x = $urandom_range(0, 608);
                win_y = $urandom_range(0, 472);
            end
            sel = (i >= HOLD_AT && i < HOLD_AT + HOLD_GETS) ? 50 : $urandom_range(0, 99);
            item = mk(REQ_PUT, win_x + $urandom_range(0, 31), $urandom_range(0, 1023),
                      win_y + $urandom_range(0, 7), $urandom_range(0, 15));
            if (sel < 35) begin
                item.req_type = REQ_PUT;
            end else if (sel < 70) begin
                item.req_type = REQ_GET;
            end else if (sel < 90) begin
                item.req_type = REQ_LINE;
                item.x_end    = X_W'(item.x + $urandom_range(0, 24));
            end else if (sel < 93) begin
                item = mk(REQ_LINE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 511), $urandom_range(0, 15));
            end else if (sel < 96) begin
                item = mk(REQ_SPARE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 511), $urandom_range(0, 15));
            end else begin
                item = mk(REQ_W'($urandom_range(0, 2)), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom_range(0, 511),
                          $urandom_range(0, 15));
            end
            send(item);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d puts, %0d gets, %0d lines and %0d unused-code requests,",
                 n_put, n_get, n_line, n_spare);
        $display("including off-screen, clipped, empty and single-byte spans; %0d reads compared.",
                 checked);
        if (fail_count == 0) begin
            $display("planar_pixel_span_engine_unit_tb: clean");
        end else begin
            $display("planar_pixel_span_engine_unit_tb: errors");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/ppse_pkg.sv
hw/rtl/ppse_req_if.sv
hw/rtl/ppse_rsp_if.sv
hw/rtl/ppse_ram.sv
hw/rtl/ppse_req_decode.sv
hw/rtl/planar_pixel_span_engine_unit.sv
hw/rtl/ppse_chk.sv
bench/planar_pixel_span_engine_unit_chk.sv
bench/planar_pixel_span_engine_unit_tb.sv
